// ----- hw/rtl/cida_pkg.sv -----
// ----------------------------------------------------------------------------
// cida_pkg
// Shared codes and widths for the cached ID pool allocator.
// ----------------------------------------------------------------------------
package cida_pkg;

	localparam int ID_W    = 32;
	localparam int COUNT_W = 13;

	// Request kinds.
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// Configuration register indexes.
	localparam logic REG_FLOOR = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

endpackage

// ----- hw/rtl/cida_ram.sv -----
// ----------------------------------------------------------------------------
// cida_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cida_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/cached_id_pool_allocator.sv -----
// ----------------------------------------------------------------------------
// cached_id_pool_allocator
// Per-user slab cache of IDs with a FIFO of full slabs and a stack of spare
// slots, run by a small sequencer over three block RAMs.
// ----------------------------------------------------------------------------
// An allocation that pops the user's own slab goes through ST_ALLOC, ST_POP
// and ST_POP_OUT; one that takes a full slab from the FIFO passes ST_ALLOC2
// and ST_FIFO_WAIT first; one that fills a fresh slab passes ST_ALLOC2,
// ST_SPR_WAIT and ST_FILL, which writes one ID a cycle through the single
// write port of the slab store; a steal scans one user a cycle in ST_STEAL.
// A free ends in ST_FREE, or passes ST_FREE2 and ST_FREE_WAIT when it must
// open a new slab. After reset and after every configuration write the pool
// is rebuilt while busy is high: a set-up state, the initial fill of each
// user's slab and then one slab slot per cycle to build the spare stack.
// Each result beat is shown on done for one cycle and must be taken then.
// ----------------------------------------------------------------------------
module cached_id_pool_allocator
	import cida_pkg::*;
#(
	parameter int NUM_USERS = 4,
	parameter int SLAB_SIZE = 32,
	parameter int MAX_IDS   = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic [1:0]         user,
	input  logic [ID_W-1:0]    id_in,
	output logic               done,
	output logic               ok,
	output logic [ID_W-1:0]    id_out,
	output logic               stolen,
	input  logic               cfg_we,
	input  logic               cfg_idx,
	input  logic [ID_W-1:0]    cfg_data
);

	localparam int NUM_SLOTS = (MAX_IDS + SLAB_SIZE - 1) / SLAB_SIZE + NUM_USERS;
	localparam int SW  = $clog2(NUM_SLOTS);
	localparam int SCW = $clog2(NUM_SLOTS + 1);
	localparam int UW  = NUM_USERS > 1 ? $clog2(NUM_USERS) : 1;
	localparam int FW  = $clog2(SLAB_SIZE + 1);
	localparam int IW  = SLAB_SIZE > 1 ? $clog2(SLAB_SIZE) : 1;
	localparam int STORE_D = NUM_SLOTS * SLAB_SIZE;
	localparam int AW  = $clog2(STORE_D);
	localparam int MW  = $clog2(MAX_IDS + 1);
	localparam int CW  = MW > COUNT_W ? MW : COUNT_W;

	localparam logic [4:0] ST_IDLE      = 5'd0;
	localparam logic [4:0] ST_INIT      = 5'd1;
	localparam logic [4:0] ST_IUSER     = 5'd2;
	localparam logic [4:0] ST_FILL      = 5'd3;
	localparam logic [4:0] ST_ISPARE    = 5'd4;
	localparam logic [4:0] ST_ALLOC     = 5'd5;
	localparam logic [4:0] ST_ALLOC2    = 5'd6;
	localparam logic [4:0] ST_FIFO_WAIT = 5'd7;
	localparam logic [4:0] ST_SPR_WAIT  = 5'd8;
	localparam logic [4:0] ST_STEAL     = 5'd9;
	localparam logic [4:0] ST_POP       = 5'd10;
	localparam logic [4:0] ST_POP_OUT   = 5'd11;
	localparam logic [4:0] ST_FREE      = 5'd12;
	localparam logic [4:0] ST_FREE2     = 5'd13;
	localparam logic [4:0] ST_FREE_WAIT = 5'd14;

	logic [4:0]         state_q;
	logic [ID_W-1:0]    floor_q;
	logic [COUNT_W-1:0] count_q;
	logic [ID_W-1:0]    ceil_q;
	logic [ID_W-1:0]    fresh_q;
	logic [SW-1:0]      fifo_head_q;
	logic [SCW-1:0]     fifo_cnt_q;
	logic [SCW-1:0]     spare_cnt_q;
	logic               valid_q [NUM_USERS];
	logic [SW-1:0]      uslot_q [NUM_USERS];
	logic [FW-1:0]      ufill_q [NUM_USERS];
	logic [UW-1:0]      user_q;
	logic [ID_W-1:0]    id_q;
	logic [UW-1:0]      iu_q;
	logic [SW-1:0]      sw_q;
	logic [SW-1:0]      fill_slot_q;
	logic [IW-1:0]      fill_idx_q;
	logic               fill_init_q;
	logic [SW-1:0]      pop_slot_q;
	logic [IW-1:0]      pop_idx_q;
	logic               steal_q;
	logic               done_q;
	logic               ok_q;
	logic [ID_W-1:0]    id_out_q;
	logic               stolen_q;

	// RAM ports.
	logic            st_we;
	logic [AW-1:0]   st_waddr;
	logic [ID_W-1:0] st_wdata;
	logic [AW-1:0]   st_raddr;
	logic [ID_W-1:0] st_rdata;
	logic            fi_we;
	logic [SW-1:0]   fi_waddr;
	logic [SW-1:0]   fi_wdata;
	logic [SW-1:0]   fi_raddr;
	logic [SW-1:0]   fi_rdata;
	logic            sp_we;
	logic [SW-1:0]   sp_waddr;
	logic [SW-1:0]   sp_wdata;
	logic [SW-1:0]   sp_raddr;
	logic [SW-1:0]   sp_rdata;

	// Shared arithmetic.
	logic [ID_W-1:0] span;
	logic [FW-1:0]   fresh_n;
	logic            have_fresh;
	logic [SCW:0]    tail_sum;
	logic [SW-1:0]   fifo_tail;
	logic [SW-1:0]   head_next;
	logic [CW-1:0]   eff_count;
	logic [ID_W:0]   ceil_sum;
	logic [ID_W-1:0] ceil_new;
	logic            user_in_range;
	logic            last_user;

	assign have_fresh = fresh_q < ceil_q;
	assign span       = ceil_q - fresh_q;
	assign fresh_n    = (span > ID_W'(SLAB_SIZE)) ? FW'(SLAB_SIZE) : FW'(span);
	assign tail_sum   = (SCW+1)'(fifo_head_q) + (SCW+1)'(fifo_cnt_q);
	assign fifo_tail  = (tail_sum >= (SCW+1)'(NUM_SLOTS)) ?
		SW'(tail_sum - (SCW+1)'(NUM_SLOTS)) : SW'(tail_sum);
	assign head_next  = (fifo_head_q == SW'(NUM_SLOTS - 1)) ? '0 : fifo_head_q + 1'b1;
	assign eff_count  = (CW'(count_q) > CW'(MAX_IDS)) ? CW'(MAX_IDS) : CW'(count_q);
	assign ceil_sum   = (ID_W+1)'(floor_q) + (ID_W+1)'(eff_count);
	assign ceil_new   = ceil_sum[ID_W] ? '1 : ceil_sum[ID_W-1:0];
	assign user_in_range = {30'd0, user} < 32'(NUM_USERS);
	assign last_user  = iu_q == UW'(NUM_USERS - 1);

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign ok     = ok_q;
	assign id_out = id_out_q;
	assign stolen = stolen_q;

	always_comb begin
		st_we    = 1'b0;
		st_waddr = '0;
		st_wdata = id_q;
		st_raddr = AW'(AW'(pop_slot_q) * AW'(SLAB_SIZE)) + AW'(pop_idx_q);
		fi_we    = 1'b0;
		fi_waddr = fifo_tail;
		fi_wdata = uslot_q[user_q];
		fi_raddr = fifo_head_q;
		sp_we    = 1'b0;
		sp_waddr = SW'(spare_cnt_q);
		sp_wdata = uslot_q[user_q];
		sp_raddr = SW'(spare_cnt_q - 1'b1);
		case (state_q)
			ST_FILL: begin
				st_we    = 1'b1;
				st_waddr = AW'(AW'(fill_slot_q) * AW'(SLAB_SIZE)) + AW'(fill_idx_q);
				st_wdata = fresh_q;
			end
			ST_ISPARE: begin
				sp_we    = !(32'(sw_q) < 32'(NUM_USERS) && valid_q[UW'(sw_q)]);
				sp_wdata = sw_q;
			end
			ST_ALLOC: begin
				// Release an empty slab to the spare stack.
				sp_we = valid_q[user_q] && ufill_q[user_q] == '0 &&
					spare_cnt_q < SCW'(NUM_SLOTS);
			end
			ST_FREE: begin
				if (id_q >= floor_q && id_q < ceil_q && valid_q[user_q]) begin
					if (ufill_q[user_q] < FW'(SLAB_SIZE)) begin
						st_we    = 1'b1;
						st_waddr = AW'(AW'(uslot_q[user_q]) * AW'(SLAB_SIZE)) +
							AW'(ufill_q[user_q]);
					end else begin
						fi_we = spare_cnt_q != '0 && fifo_cnt_q < SCW'(NUM_SLOTS);
					end
				end
			end
			ST_FREE_WAIT: begin
				st_we    = 1'b1;
				st_waddr = AW'(AW'(sp_rdata) * AW'(SLAB_SIZE));
			end
			default: begin
			end
		endcase
	end

	cida_ram #(.WIDTH(ID_W), .DEPTH(STORE_D)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	cida_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_fifo (
		.clk   (clk),
		.we    (fi_we),
		.waddr (fi_waddr),
		.wdata (fi_wdata),
		.raddr (fi_raddr),
		.rdata (fi_rdata)
	);

	cida_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_spare (
		.clk   (clk),
		.we    (sp_we),
		.waddr (sp_waddr),
		.wdata (sp_wdata),
		.raddr (sp_raddr),
		.rdata (sp_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			floor_q     <= '0;
			count_q     <= COUNT_RESET;
			ceil_q      <= '0;
			fresh_q     <= '0;
			fifo_head_q <= '0;
			fifo_cnt_q  <= '0;
			spare_cnt_q <= '0;
			for (int i = 0; i < NUM_USERS; i++) begin
				valid_q[i] <= 1'b0;
				uslot_q[i] <= SW'(i);
				ufill_q[i] <= '0;
			end
			iu_q        <= '0;
			sw_q        <= '0;
			fill_init_q <= 1'b0;
			steal_q     <= 1'b0;
			done_q      <= 1'b0;
			ok_q        <= 1'b0;
			id_out_q    <= '0;
			stolen_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_idx == REG_FLOOR) begin
					floor_q <= cfg_data;
				end else begin
					count_q <= cfg_data[COUNT_W-1:0];
				end
				state_q <= ST_INIT;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (start) begin
							user_q <= UW'(user);
							id_q   <= id_in;
							if (!user_in_range) begin
								done_q   <= 1'b1;
								ok_q     <= 1'b0;
								id_out_q <= '0;
								stolen_q <= 1'b0;
							end else if (kind == KIND_ALLOC) begin
								state_q <= ST_ALLOC;
							end else begin
								state_q <= ST_FREE;
							end
						end
					end
					ST_INIT: begin
						ceil_q      <= ceil_new;
						fresh_q     <= floor_q;
						fifo_head_q <= '0;
						fifo_cnt_q  <= '0;
						spare_cnt_q <= '0;
						for (int i = 0; i < NUM_USERS; i++) begin
							valid_q[i] <= 1'b0;
						end
						iu_q    <= '0;
						state_q <= ST_IUSER;
					end
					ST_IUSER: begin
						uslot_q[iu_q] <= SW'(iu_q);
						if (have_fresh) begin
							valid_q[iu_q] <= 1'b1;
							ufill_q[iu_q] <= fresh_n;
							fill_slot_q   <= SW'(iu_q);
							fill_idx_q    <= IW'(fresh_n - 1'b1);
							fill_init_q   <= 1'b1;
							state_q       <= ST_FILL;
						end else begin
							ufill_q[iu_q] <= '0;
							if (last_user) begin
								sw_q    <= SW'(NUM_SLOTS - 1);
								state_q <= ST_ISPARE;
							end else begin
								iu_q <= iu_q + 1'b1;
							end
						end
					end
					ST_FILL: begin
						// The lowest ID lands on top of the slab.
						fresh_q <= fresh_q + 1'b1;
						if (fill_idx_q == '0) begin
							if (fill_init_q) begin
								if (last_user) begin
									sw_q    <= SW'(NUM_SLOTS - 1);
									state_q <= ST_ISPARE;
								end else begin
									iu_q    <= iu_q + 1'b1;
									state_q <= ST_IUSER;
								end
							end else begin
								ufill_q[user_q] <= ufill_q[user_q] - 1'b1;
								pop_idx_q       <= IW'(ufill_q[user_q] - 1'b1);
								pop_slot_q      <= fill_slot_q;
								steal_q         <= 1'b0;
								state_q         <= ST_POP;
							end
						end else begin
							fill_idx_q <= fill_idx_q - 1'b1;
						end
					end
					ST_ISPARE: begin
						if (!(32'(sw_q) < 32'(NUM_USERS) && valid_q[UW'(sw_q)])) begin
							spare_cnt_q <= spare_cnt_q + 1'b1;
						end
						if (sw_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							sw_q <= sw_q - 1'b1;
						end
					end
					ST_ALLOC: begin
						if (valid_q[user_q] && ufill_q[user_q] != '0) begin
							ufill_q[user_q] <= ufill_q[user_q] - 1'b1;
							pop_idx_q       <= IW'(ufill_q[user_q] - 1'b1);
							pop_slot_q      <= uslot_q[user_q];
							steal_q         <= 1'b0;
							state_q         <= ST_POP;
						end else begin
							if (valid_q[user_q]) begin
								if (spare_cnt_q < SCW'(NUM_SLOTS)) begin
									spare_cnt_q <= spare_cnt_q + 1'b1;
								end
								valid_q[user_q] <= 1'b0;
							end
							state_q <= ST_ALLOC2;
						end
					end
					ST_ALLOC2: begin
						if (fifo_cnt_q != '0) begin
							fifo_head_q <= head_next;
							fifo_cnt_q  <= fifo_cnt_q - 1'b1;
							state_q     <= ST_FIFO_WAIT;
						end else if (spare_cnt_q != '0 && have_fresh) begin
							spare_cnt_q <= spare_cnt_q - 1'b1;
							state_q     <= ST_SPR_WAIT;
						end else begin
							iu_q    <= '0;
							state_q <= ST_STEAL;
						end
					end
					ST_FIFO_WAIT: begin
						// Slabs in the FIFO are always full.
						uslot_q[user_q] <= fi_rdata;
						valid_q[user_q] <= 1'b1;
						ufill_q[user_q] <= FW'(SLAB_SIZE - 1);
						pop_slot_q      <= fi_rdata;
						pop_idx_q       <= IW'(SLAB_SIZE - 1);
						steal_q         <= 1'b0;
						state_q         <= ST_POP;
					end
					ST_SPR_WAIT: begin
						uslot_q[user_q] <= sp_rdata;
						valid_q[user_q] <= 1'b1;
						ufill_q[user_q] <= fresh_n;
						fill_slot_q     <= sp_rdata;
						fill_idx_q      <= IW'(fresh_n - 1'b1);
						fill_init_q     <= 1'b0;
						state_q         <= ST_FILL;
					end
					ST_STEAL: begin
						if (iu_q != user_q && valid_q[iu_q] && ufill_q[iu_q] != '0) begin
							ufill_q[iu_q] <= ufill_q[iu_q] - 1'b1;
							pop_idx_q     <= IW'(ufill_q[iu_q] - 1'b1);
							pop_slot_q    <= uslot_q[iu_q];
							steal_q       <= 1'b1;
							state_q       <= ST_POP;
						end else if (last_user) begin
							done_q   <= 1'b1;
							ok_q     <= 1'b0;
							id_out_q <= '0;
							stolen_q <= 1'b0;
							state_q  <= ST_IDLE;
						end else begin
							iu_q <= iu_q + 1'b1;
						end
					end
					ST_POP: begin
						state_q <= ST_POP_OUT;
					end
					ST_POP_OUT: begin
						done_q   <= 1'b1;
						ok_q     <= 1'b1;
						id_out_q <= st_rdata;
						stolen_q <= steal_q;
						state_q  <= ST_IDLE;
					end
					ST_FREE: begin
						if (id_q < floor_q || id_q >= ceil_q) begin
							done_q   <= 1'b1;
							ok_q     <= 1'b0;
							id_out_q <= '0;
							stolen_q <= 1'b0;
							state_q  <= ST_IDLE;
						end else if (valid_q[user_q] &&
								ufill_q[user_q] < FW'(SLAB_SIZE)) begin
							ufill_q[user_q] <= ufill_q[user_q] + 1'b1;
							done_q   <= 1'b1;
							ok_q     <= 1'b1;
							id_out_q <= '0;
							stolen_q <= 1'b0;
							state_q  <= ST_IDLE;
						end else if (valid_q[user_q]) begin
							if (spare_cnt_q == '0 || fifo_cnt_q >= SCW'(NUM_SLOTS)) begin
								done_q   <= 1'b1;
								ok_q     <= 1'b0;
								id_out_q <= '0;
								stolen_q <= 1'b0;
								state_q  <= ST_IDLE;
							end else begin
								// The full slab joins the FIFO tail.
								fifo_cnt_q      <= fifo_cnt_q + 1'b1;
								valid_q[user_q] <= 1'b0;
								state_q         <= ST_FREE2;
							end
						end else begin
							state_q <= ST_FREE2;
						end
					end
					ST_FREE2: begin
						if (spare_cnt_q == '0) begin
							done_q   <= 1'b1;
							ok_q     <= 1'b0;
							id_out_q <= '0;
							stolen_q <= 1'b0;
							state_q  <= ST_IDLE;
						end else begin
							spare_cnt_q <= spare_cnt_q - 1'b1;
							state_q     <= ST_FREE_WAIT;
						end
					end
					ST_FREE_WAIT: begin
						uslot_q[user_q] <= sp_rdata;
						valid_q[user_q] <= 1'b1;
						ufill_q[user_q] <= FW'(1);
						done_q   <= 1'b1;
						ok_q     <= 1'b1;
						id_out_q <= '0;
						stolen_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
					default: begin
						state_q <= ST_INIT;
					end
				endcase
			end
		end
	end

endmodule

// ----- verif/cached_id_pool_allocator_test.sv -----
// ----------------------------------------------------------------------------
// cached_id_pool_allocator_test
// Self-checking bench for the cached ID pool allocator. A directed table of
// requests is run first, then random allocate and free beats over several
// pool settings. Every result beat is checked against a behavioural model
// of the slab cache, full-slab FIFO and spare-slot stack.
// ----------------------------------------------------------------------------
module cached_id_pool_allocator_test
	import cida_pkg::*;
();

	localparam int USERS     = 4;
	localparam int SLAB      = 32;
	localparam int POOL_MAX  = 4096;
	localparam int SLOTS     = (POOL_MAX + SLAB - 1) / SLAB + USERS;
	localparam int WDOG_MAX  = 20000;
	localparam int SETTLE    = 400;

	typedef struct packed {
		logic            ok;
		logic [ID_W-1:0] id;
		logic            stolen;
	} result_t;

	typedef struct {
		logic            kind;
		logic [1:0]      user;
		logic [ID_W-1:0] id;
		logic            known;
		result_t         res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic kind = KIND_ALLOC;
	logic [1:0] user = '0;
	logic [ID_W-1:0] id_in = '0;
	logic cfg_we = 1'b0;
	logic cfg_idx = REG_FLOOR;
	logic [ID_W-1:0] cfg_data = '0;
	logic busy, done, ok, stolen;
	logic [ID_W-1:0] id_out;

	cached_id_pool_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .user(user), .id_in(id_in), .done(done), .ok(ok),
		.id_out(id_out), .stolen(stolen), .cfg_we(cfg_we),
		.cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Model state.
	logic [ID_W-1:0] m_floor, m_ceil, m_fresh;
	logic [COUNT_W-1:0] m_count;
	logic [ID_W-1:0] m_store [SLOTS][SLAB];
	int m_fill [SLOTS];
	int m_uslot [USERS];
	bit m_uvalid [USERS];
	int m_fifo [SLOTS];
	int m_fhead, m_fcnt;
	int m_spare [SLOTS];
	int m_scnt;

	result_t pending_results [$];
	int errors = 0;
	int wdog = 0;
	bit quiet = 1'b0;

	function automatic bit fill_slab(int s);
		logic [ID_W-1:0] n;
		if (m_fresh >= m_ceil)
			return 0;
		n = m_ceil - m_fresh;
		if (n > SLAB)
			n = SLAB;
		for (int p = int'(n); p > 0; p--) begin
			m_store[s][p-1] = m_fresh;
			m_fresh++;
		end
		m_fill[s] = int'(n);
		return 1;
	endfunction

	function automatic bit pop_slab(int s, output logic [ID_W-1:0] id);
		id = '0;
		if (m_fill[s] == 0)
			return 0;
		m_fill[s]--;
		id = m_store[s][m_fill[s]];
		return 1;
	endfunction

	function automatic void push_spare(int s);
		if (m_scnt < SLOTS) begin
			m_spare[m_scnt] = s;
			m_scnt++;
		end
	endfunction

	function automatic void rebuild_pool();
		longint unsigned c, top;
		c = (m_count > POOL_MAX) ? POOL_MAX : m_count;
		top = longint'(m_floor) + c;
		if (top > 64'hFFFF_FFFF)
			top = 64'hFFFF_FFFF;
		m_ceil = top[ID_W-1:0];
		m_fresh = m_floor;
		foreach (m_fill[s])
			m_fill[s] = 0;
		m_fhead = 0;
		m_fcnt = 0;
		m_scnt = 0;
		for (int u = 0; u < USERS; u++) begin
			m_uslot[u] = u;
			m_uvalid[u] = fill_slab(u);
		end
		for (int s = SLOTS; s > 0; s--) begin
			if (s - 1 < USERS && m_uvalid[s-1])
				continue;
			push_spare(s - 1);
		end
	endfunction

	function automatic bit alloc_id(int u, output logic [ID_W-1:0] id, output bit stl);
		int s;
		stl = 0;
		id = '0;
		if (m_uvalid[u] && pop_slab(m_uslot[u], id))
			return 1;
		if (m_uvalid[u]) begin
			push_spare(m_uslot[u]);
			m_uvalid[u] = 0;
		end
		if (m_fcnt > 0) begin
			s = m_fifo[m_fhead];
			m_fhead = (m_fhead + 1) % SLOTS;
			m_fcnt--;
			m_uslot[u] = s;
			m_uvalid[u] = 1;
			return pop_slab(s, id);
		end
		if (m_scnt > 0 && m_fresh < m_ceil) begin
			m_scnt--;
			s = m_spare[m_scnt];
			void'(fill_slab(s));
			m_uslot[u] = s;
			m_uvalid[u] = 1;
			return pop_slab(s, id);
		end
		for (int v = 0; v < USERS; v++) begin
			if (v == u || !m_uvalid[v])
				continue;
			if (pop_slab(m_uslot[v], id)) begin
				stl = 1;
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic bit free_id(int u, logic [ID_W-1:0] id);
		int s;
		if (id < m_floor || id >= m_ceil)
			return 0;
		if (m_uvalid[u]) begin
			s = m_uslot[u];
			if (m_fill[s] < SLAB) begin
				m_store[s][m_fill[s]] = id;
				m_fill[s]++;
				return 1;
			end
			if (m_scnt == 0 || m_fcnt >= SLOTS)
				return 0;
			m_fifo[(m_fhead + m_fcnt) % SLOTS] = s;
			m_fcnt++;
			m_uvalid[u] = 0;
		end
		if (m_scnt == 0)
			return 0;
		m_scnt--;
		s = m_spare[m_scnt];
		m_store[s][0] = id;
		m_fill[s] = 1;
		m_uslot[u] = s;
		m_uvalid[u] = 1;
		return 1;
	endfunction

	function automatic result_t pool_step(logic k, logic [1:0] u, logic [ID_W-1:0] id);
		result_t r;
		logic [ID_W-1:0] got;
		bit stl;
		r = '0;
		if (k == KIND_ALLOC) begin
			r.ok = alloc_id(int'(u), got, stl);
			if (r.ok) begin
				r.id = got;
				r.stolen = stl;
			end
		end else begin
			r.ok = free_id(int'(u), id);
		end
		return r;
	endfunction

	// Result beats are checked at the edge that ends their cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				result_t e;
				e = pending_results.pop_front();
				if (ok !== e.ok) begin
					$error("ok expected %0d actual %0d", e.ok, ok);
					errors++;
				end
				if (id_out !== e.id) begin
					$error("id_out expected %0h actual %0h", e.id, id_out);
					errors++;
				end
				if (stolen !== e.stolen) begin
					$error("stolen expected %0d actual %0d", e.stolen, stolen);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (done || (start && !busy) || cfg_we)
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Presents one beat and waits until it is taken. Start stays high after
	// the accepting edge; the block is busy then, so nothing more is taken.
	task automatic send_request(logic k, logic [1:0] u, logic [ID_W-1:0] id,
			bit known, result_t res);
		result_t p;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		user <= u;
		id_in <= id;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		p = pool_step(k, u, id);
		pending_results.push_back(p);
		if (known && p !== res) begin
			$error("table row mismatch: expected %h model %h", res, p);
			errors++;
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Registers are only written with the pool idle.
	task automatic write_reg(logic idx, logic [ID_W-1:0] val);
		drain_results();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FLOOR)
			m_floor = val;
		else
			m_count = val[COUNT_W-1:0];
		rebuild_pool();
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	function automatic logic [ID_W-1:0] pick_id();
		int r;
		logic [ID_W-1:0] span;
		span = m_ceil - m_floor;
		r = $urandom_range(0, 9);
		if (r == 0)
			return $urandom();
		if (r == 1)
			return m_floor - 1;
		if (r == 2)
			return m_ceil;
		if (span == 0)
			return m_floor;
		return m_floor + ($urandom() % span);
	endfunction

	task automatic random_phase(int n, int free_pct);
		logic [ID_W-1:0] held [$];
		logic k;
		logic [1:0] u;
		logic [ID_W-1:0] id;
		result_t p;
		for (int i = 0; i < n; i++) begin
			k = ($urandom_range(0, 99) < free_pct) ? KIND_FREE : KIND_ALLOC;
			u = 2'($urandom_range(0, 3));
			if (k == KIND_FREE && held.size() != 0 && $urandom_range(0, 3) != 0)
				id = held.pop_front();
			else
				id = (k == KIND_FREE) ? pick_id() : $urandom();
			send_request(k, u, id, 0, '0);
			p = pending_results[$];
			if (k == KIND_ALLOC && p.ok)
				held.push_back(p.id);
		end
	endtask

	row_t steps [$];

	initial begin
		result_t none;
		none = '0;
		m_floor = '0;
		m_count = COUNT_RESET;
		rebuild_pool();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);

		// After reset user 0 holds IDs 0..31 with 0 on top.
		steps.push_back('{KIND_ALLOC, 2'd0, 32'h0, 1, '{1'b1, 32'd0, 1'b0}});
		steps.push_back('{KIND_ALLOC, 2'd3, 32'hFFFF_FFFF, 1, '{1'b1, 32'd96, 1'b0}});
		steps.push_back('{KIND_FREE, 2'd1, 32'hFFFF_FFFF, 1, none});
		steps.push_back('{KIND_FREE, 2'd2, 32'd4096, 1, none});
		steps.push_back('{KIND_FREE, 2'd2, 32'd4095, 1, '{1'b1, 32'd0, 1'b0}});
		steps.push_back('{KIND_ALLOC, 2'd2, 32'h0, 1, '{1'b1, 32'd4095, 1'b0}});
		steps.push_back('{KIND_FREE, 2'd0, 32'd0, 1, '{1'b1, 32'd0, 1'b0}});
		steps.push_back('{KIND_ALLOC, 2'd1, 32'h5555_AAAA, 0, none});
		foreach (steps[i])
			send_request(steps[i].kind, steps[i].user, steps[i].id,
				steps[i].known, steps[i].res);
		// Fill user 1's slab past full so it goes to the FIFO.
		for (int i = 0; i < 34; i++)
			send_request(KIND_FREE, 2'd1, 32'd200 + i, 0, none);

		// Tiny pool at the top of the range: exhaustion and stealing.
		write_reg(REG_FLOOR, 32'hFFFF_FFF0);
		write_reg(REG_COUNT, 32'd5);
		for (int i = 0; i < 8; i++)
			send_request(KIND_ALLOC, i[1:0], 32'h0, 0, none);
		send_request(KIND_FREE, 2'd3, 32'hFFFF_FFFF, 1, none);
		send_request(KIND_FREE, 2'd3, 32'hFFFF_FFF0, 1, '{1'b1, 32'd0, 1'b0});
		random_phase(40, 45);

		// Count zero: every request fails.
		write_reg(REG_COUNT, 32'd0);
		send_request(KIND_ALLOC, 2'd0, 32'h0, 1, none);
		send_request(KIND_FREE, 2'd0, 32'hFFFF_FFF0, 1, none);

		// Count over the maximum, small floor.
		write_reg(REG_FLOOR, 32'd0);
		write_reg(REG_COUNT, 32'h1FFF);
		random_phase(120, 50);

		// Small pool with a mid-range floor: slots churn quickly.
		write_reg(REG_FLOOR, 32'h8000_0000 | $urandom_range(0, 1000));
		write_reg(REG_COUNT, 32'd70);
		random_phase(120, 45);

		write_reg(REG_FLOOR, $urandom());
		write_reg(REG_COUNT, 32'($urandom_range(1, 300)));
		quiet = 1'b1;
		random_phase(120, 50);

		drain_results();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- cached_id_pool_allocator.f -----
hw/rtl/cida_pkg.sv
hw/rtl/cida_ram.sv
hw/rtl/cached_id_pool_allocator.sv
verif/cached_id_pool_allocator_test.sv
